/* hdl/positional_ordered_list_assert.svh */
// Assertion macros shared by the list RTL.
// Needs i_clk and i_rst_n in the scope of the module that uses them.
`ifndef POSITIONAL_ORDERED_LIST_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_ASSERT_SVH

// Check that an expression holds at every clock edge out of reset.
`define POL_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("list invariant violated");

// Check that a consequent holds in the cycle after its trigger.
`define POL_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error("list next-cycle check failed");

`endif

/* hdl/pol_pkg.sv */
// Shared types, sizes and conversion functions for the positional list.
// No dependencies.
package pol_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 7;
    localparam int CMD_W      = 3;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_UPDATE = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_CLEAR  = 3'd4,
        CMD_READ   = 3'd5
    } t_cmd;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [DATA_WIDTH-1:0]     t_entry;
    typedef logic [CMP_W-1:0]          t_cmp;

    // Command broadcast to every cell; en is high only for an accepted,
    // successful command.
    typedef struct packed {
        logic   en;
        t_cmd   cmd;
        t_cmp   pos;
        t_cmp   count;
        t_entry value;
    } t_bcast;

    function automatic t_entry to_entry(input t_value v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[DATA_WIDTH-1:0];
    endfunction

    function automatic t_value from_entry(input t_entry e);
        logic signed [63:0] w;
        w = 64'(signed'(e));
        return w[VALUE_W-1:0];
    endfunction

endpackage

/* hdl/pol_if.sv */
// Valid/ready channel interfaces for list commands and results.
// Depends on pol_pkg.
interface pol_cmd_if;
    import pol_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    t_value               value;
    logic [POS_W-1:0]     position;
    modport source (output valid, output cmd, output value, output position, input ready);
    modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

interface pol_res_if;
    import pol_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [POS_W-1:0]     count;
    t_value               read_value;
    modport source (output valid, output ok, output count, output read_value, input ready);
    modport sink   (input valid, input ok, input count, input read_value, output ready);
endinterface

/* hdl/pol_cell.sv */
// One storage cell of the list row: holds one entry and loads from the
// command value or a neighbor. Depends on pol_pkg.
module pol_cell (
    input  logic            i_clk,
    input  pol_pkg::t_cmp   i_index,
    input  pol_pkg::t_bcast i_bcast,
    input  pol_pkg::t_entry i_left,
    input  pol_pkg::t_entry i_right,
    output pol_pkg::t_entry o_data
);
    import pol_pkg::*;

    typedef enum logic [1:0] {MV_HOLD, MV_VALUE, MV_LEFT, MV_RIGHT} t_move;

    t_move          w_move;
    t_entry         r_data;
    t_entry         n_data;
    logic [CMP_W:0] w_next_idx;

    assign w_next_idx = {1'b0, i_index} + (CMP_W + 1)'(1);

    always_comb begin
        w_move = MV_HOLD;
        if (i_bcast.en) begin
            unique case (i_bcast.cmd)
                CMD_APPEND: if (i_index == i_bcast.count) w_move = MV_VALUE;
                CMD_INSERT: begin
                    if (i_index == i_bcast.pos)
                        w_move = MV_VALUE;
                    else if (i_index > i_bcast.pos && i_index <= i_bcast.count)
                        w_move = MV_LEFT;
                end
                CMD_UPDATE: if (i_index == i_bcast.pos) w_move = MV_VALUE;
                CMD_DELETE: begin
                    if (i_index >= i_bcast.pos && w_next_idx < {1'b0, i_bcast.count})
                        w_move = MV_RIGHT;
                end
                default: w_move = MV_HOLD;
            endcase
        end
    end

    always_comb begin
        unique case (w_move)
            MV_VALUE: n_data = i_bcast.value;
            MV_LEFT:  n_data = i_left;
            MV_RIGHT: n_data = i_right;
            default:  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* hdl/positional_ordered_list.sv */
// Top level of the positional ordered list: command channel in, result
// channel out, a row of pol_cell instances holding the entries.
// Depends on pol_pkg, pol_if, pol_cell and positional_ordered_list_assert.svh.
//
// Usage:
//   i_cmd carries one command per beat: cmd, value, position. o_res returns
//   exactly one result beat per command: ok, count and read_value.
//   Each cell holds one entry. Insert, delete, append and update rewrite
//   the whole row in the cycle the command is accepted: every cell loads
//   the command value, its left neighbor, its right neighbor, or holds.
//   A read selects the addressed cell and lands in the result register.
//   The result is registered and is valid in the cycle after the command beat.
//   Throughput: one command per cycle; the single result register is the
//   only storage between the channels, so a new command is taken whenever
//   that register is empty or being drained in the same cycle.
//   When the receiver stalls, the result holds and i_cmd.ready drops until
//   it is taken; no command is lost or reordered.
//   Reset clears the entry count and the result valid; cell contents are
//   left as they are and are never read before being written.
module positional_ordered_list (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pol_cmd_if.sink   i_cmd,
    pol_res_if.source o_res
);
    import pol_pkg::*;

    `include "positional_ordered_list_assert.svh"

    logic             w_fire;
    logic             w_ok;
    logic             w_not_full;
    logic             w_in_range;
    t_cmp             w_pos;
    t_cmp             w_cnt;
    t_bcast           w_bcast;
    t_entry           w_cells [CAPACITY];
    t_value           w_rd;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_valid;
    logic             r_ok;
    logic [POS_W-1:0] r_cnt_out;
    t_value           r_rd;

    // Accept out of reset when the result slot is free or emptying this cycle.
    assign i_cmd.ready = i_rst_n && (!r_valid || o_res.ready);
    assign w_fire      = i_cmd.valid && i_cmd.ready;

    assign w_pos      = CMP_W'(i_cmd.position);
    assign w_cnt      = CMP_W'(r_count);
    assign w_not_full = r_count < CNT_W'(CAPACITY);
    assign w_in_range = w_pos < w_cnt;

    // Decide success and the new count.
    always_comb begin
        w_ok    = 1'b0;
        n_count = r_count;
        unique case (i_cmd.cmd)
            CMD_APPEND: if (w_not_full) begin
                w_ok    = 1'b1;
                n_count = r_count + CNT_W'(1);
            end
            CMD_INSERT: if (w_not_full && w_pos <= w_cnt) begin
                w_ok    = 1'b1;
                n_count = r_count + CNT_W'(1);
            end
            CMD_UPDATE: w_ok = w_in_range;
            CMD_DELETE: if (w_in_range) begin
                w_ok    = 1'b1;
                n_count = r_count - CNT_W'(1);
            end
            CMD_CLEAR: begin
                w_ok    = 1'b1;
                n_count = '0;
            end
            CMD_READ: w_ok = w_in_range;
            default: w_ok = 1'b0;
        endcase
    end

    assign w_bcast.en    = w_fire && w_ok;
    assign w_bcast.cmd   = t_cmd'(i_cmd.cmd);
    assign w_bcast.pos   = w_pos;
    assign w_bcast.count = w_cnt;
    assign w_bcast.value = to_entry(i_cmd.value);

    // Row of cells; the ends see zero from the missing neighbor.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cells[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cells[g+1];
        end
        pol_cell u_cell (
            .i_clk   (i_clk),
            .i_index (CMP_W'(g)),
            .i_bcast (w_bcast),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cells[g])
        );
    end

    // Read data: zero unless a successful read.
    assign w_rd = (t_cmd'(i_cmd.cmd) == CMD_READ && w_in_range)
                ? from_entry(w_cells[i_cmd.position[IDX_W-1:0]]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on every accepted command, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_ok      <= w_ok;
            r_cnt_out <= POS_W'(n_count);
            r_rd      <= w_rd;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.ok         = r_ok;
    assign o_res.count      = r_cnt_out;
    assign o_res.read_value = r_rd;

    `POL_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(CAPACITY))
    `POL_ASSERT_NEXT(a_clear_empties, w_fire && i_cmd.cmd == CMD_CLEAR, r_valid && r_count == '0)
    `POL_ASSERT_NEXT(a_reject_keeps, w_fire && !w_ok, r_count == $past(r_count))
    `POL_ASSERT_NEXT(a_append_grows, w_fire && w_ok && i_cmd.cmd == CMD_APPEND,
                     r_count == $past(r_count) + CNT_W'(1))
    `POL_ASSERT_ALWAYS(a_fail_no_data, !(r_valid && !r_ok) || r_rd == '0)

endmodule

/* bench/tb_positional_ordered_list.sv */
// Self-checking bench for positional_ordered_list: directed and random list commands.
// Keeps its own copy of the list to predict each result beat.
// Depends on pol_pkg, pol_if and the positional_ordered_list RTL.
module tb_positional_ordered_list;
    import pol_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 11;
    localparam int IDLE_PCT     = 37;
    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 8;
    localparam int POS_SPAN     = (1 << POS_W) - 1;

    // Command codes outside the defined set; the block must reject them.
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    localparam t_value VAL_MAX = 32'sh7FFF_FFFF;
    localparam t_value VAL_MIN = 32'sh8000_0000;

    typedef struct {
        logic             ok;
        logic [POS_W-1:0] count;
        t_value           read_value;
    } t_list_reply;

    // Mirror of the list contents; predicts one reply per accepted command.
    class list_mirror;
        t_entry      cells[CAPACITY];
        int unsigned length;
        t_list_reply awaited[$];
        int unsigned errors;

        // Sign-extend the 32-bit value, keep the low DATA_WIDTH bits.
        function t_entry stored_form(input t_value v);
            return t_entry'({{(64 - VALUE_W){v[VALUE_W-1]}}, v});
        endfunction

        // Sign-extend the stored word, return its low 32 bits.
        function t_value read_form(input t_entry e);
            logic [63:0] wide;
            wide = {{(64 - DATA_WIDTH){e[DATA_WIDTH-1]}}, e};
            return wide[VALUE_W-1:0];
        endfunction

        function void note_command(input logic [CMD_W-1:0] code, input t_value v,
                                   input logic [POS_W-1:0] p);
            t_list_reply r;
            t_entry      word;
            int unsigned at;
            int unsigned i;
            word         = stored_form(v);
            at           = p;
            r.ok         = 1'b0;
            r.read_value = '0;
            case (code)
                CMD_APPEND: begin
                    if (length < CAPACITY) begin
                        cells[length] = word;
                        length++;
                        r.ok = 1'b1;
                    end
                end
                CMD_INSERT: begin
                    if (length < CAPACITY && at <= length) begin
                        for (i = length; i > at; i--)
                            cells[i] = cells[i-1];
                        cells[at] = word;
                        length++;
                        r.ok = 1'b1;
                    end
                end
                CMD_UPDATE: begin
                    if (at < length) begin
                        cells[at] = word;
                        r.ok = 1'b1;
                    end
                end
                CMD_DELETE: begin
                    if (at < length) begin
                        for (i = at; i + 1 < length; i++)
                            cells[i] = cells[i+1];
                        length--;
                        r.ok = 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    length = 0;
                    r.ok   = 1'b1;
                end
                CMD_READ: begin
                    if (at < length) begin
                        r.read_value = read_form(cells[at]);
                        r.ok         = 1'b1;
                    end
                end
                default: ;
            endcase
            r.count = POS_W'(length);
            awaited.push_back(r);
        endfunction

        function void check_reply(input logic ok, input logic [POS_W-1:0] count,
                                  input t_value rv);
            t_list_reply want;
            if (awaited.size() == 0) begin
                $error("unexpected result beat: ok=%0b count=%0d read_value=%0d",
                       ok, count, rv);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (ok !== want.ok) begin
                $error("ok: expected %0b, actual %0b", want.ok, ok);
                errors++;
            end
            if (count !== want.count) begin
                $error("count: expected %0d, actual %0d", want.count, count);
                errors++;
            end
            if (rv !== want.read_value) begin
                $error("read_value: expected %0d, actual %0d", want.read_value, rv);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm;          // high: neither side idles
    list_mirror mirror;

    pol_cmd_if cmd_if ();
    pol_res_if res_if ();

    positional_ordered_list dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Receiver: drop ready at random, with a chance of IDLE_PCT percent, unless calm.
    always @(posedge i_clk)
        res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // Check every result beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            mirror.check_reply(res_if.ok, res_if.count, res_if.read_value);
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no beat on either channel for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Present one command beat, with random idle cycles ahead of it, and hold it
    // until the block takes it. Record the prediction at the accepting edge.
    task automatic push_command(input logic [CMD_W-1:0] code, input t_value v,
                                input logic [POS_W-1:0] p);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.cmd      <= code;
        cmd_if.value    <= v;
        cmd_if.position <= p;
        @(posedge i_clk);
        while (!cmd_if.ready)
            @(posedge i_clk);
        mirror.note_command(code, v, p);
    endtask

    // Lower valid and hold off until every predicted result has come back.
    task automatic drain_replies();
        cmd_if.valid <= 1'b0;
        while (mirror.awaited.size() != 0)
            @(posedge i_clk);
    endtask

    // Bias values toward the extremes now and then.
    function automatic t_value pick_value();
        case ($urandom_range(15))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return t_value'(-1);
            default: return t_value'($urandom);
        endcase
    endfunction

    // Random commands: mostly well-formed against the current length, with a
    // share of noise (any code, any position). grow_pct steers the list length.
    task automatic random_burst(input int unsigned beats, input int unsigned grow_pct,
                                input int unsigned clear_pct);
        int unsigned      k;
        int unsigned      roll;
        int unsigned      len;
        logic [CMD_W-1:0] code;
        logic [POS_W-1:0] p;
        for (k = 0; k < beats; k++) begin
            len  = mirror.length;
            roll = $urandom_range(99);
            p    = (len == 0) ? '0 : POS_W'($urandom_range(len - 1));
            if (roll < 8) begin
                code = CMD_W'($urandom_range(7));
                p    = POS_W'($urandom_range(POS_SPAN));
            end else if (roll < 8 + clear_pct) begin
                code = CMD_CLEAR;
                p    = POS_W'($urandom_range(POS_SPAN));
            end else if ($urandom_range(99) < grow_pct) begin
                if ($urandom_range(1)) begin
                    code = CMD_APPEND;
                end else begin
                    code = CMD_INSERT;
                    p    = POS_W'($urandom_range(len));
                end
            end else begin
                roll = $urandom_range(9);
                if (roll < 5)
                    code = CMD_DELETE;
                else if (roll < 8)
                    code = CMD_READ;
                else
                    code = CMD_UPDATE;
            end
            push_command(code, pick_value(), p);
        end
    endtask

    initial begin : stimulus
        int unsigned n;
        mirror          = new;
        calm            = 1'b0;
        i_rst_n         <= 1'b0;
        cmd_if.valid    <= 1'b0;
        cmd_if.cmd      <= CMD_APPEND;
        cmd_if.value    <= '0;
        cmd_if.position <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: every positional command fails, insert past the end too.
        push_command(CMD_READ,   32'sd1, 7'd0);
        push_command(CMD_UPDATE, 32'sd2, 7'd0);
        push_command(CMD_DELETE, 32'sd3, 7'd0);
        push_command(CMD_INSERT, 32'sd4, 7'd1);
        // Build a short list from the value extremes, inserting at head, end, middle.
        push_command(CMD_INSERT, VAL_MAX, 7'd0);
        push_command(CMD_APPEND, VAL_MIN, 7'd0);
        push_command(CMD_APPEND, t_value'(-1), 7'd0);
        push_command(CMD_INSERT, 32'sh5555_5555, 7'd3);
        push_command(CMD_INSERT, 32'shAAAA_AAAA, 7'd1);
        push_command(CMD_INSERT, 32'sd5, 7'd127);
        // Reads at both ends and just past the end.
        push_command(CMD_READ,   '0, 7'd0);
        push_command(CMD_READ,   '0, 7'd4);
        push_command(CMD_READ,   '0, 7'd5);
        push_command(CMD_READ,   '0, 7'd127);
        push_command(CMD_UPDATE, '0, 7'd2);
        push_command(CMD_UPDATE, 32'sd6, 7'd5);
        // Delete head and tail, then out of range.
        push_command(CMD_DELETE, '0, 7'd0);
        push_command(CMD_DELETE, '0, 7'd3);
        push_command(CMD_DELETE, '0, 7'd64);
        // Undefined codes do nothing.
        push_command(CMD_UNUSED_6, VAL_MAX, 7'd0);
        push_command(CMD_UNUSED_7, t_value'(-1), 7'd127);
        push_command(CMD_READ,   '0, 7'd1);
        // Clear succeeds, also on an empty list.
        push_command(CMD_CLEAR,  '0, 7'd0);
        push_command(CMD_CLEAR,  '0, 7'd0);
        push_command(CMD_READ,   '0, 7'd0);

        // Fill to capacity, then hit the full-list rejections.
        for (n = 0; n < CAPACITY; n++)
            push_command(CMD_APPEND, pick_value(), '0);
        push_command(CMD_APPEND, 32'sd7, 7'd0);
        push_command(CMD_INSERT, 32'sd8, 7'd0);
        push_command(CMD_INSERT, 32'sd9, 7'd64);
        push_command(CMD_READ,   '0, 7'(CAPACITY - 1));
        push_command(CMD_UPDATE, VAL_MIN, 7'(CAPACITY - 1));
        push_command(CMD_READ,   '0, 7'(CAPACITY - 1));
        push_command(CMD_DELETE, '0, 7'(CAPACITY - 1));

        // Random phases: grow to full, hover near full, shrink to empty, then mixed.
        random_burst(200, 85, 0);
        random_burst(200, 50, 0);
        drain_replies();
        random_burst(200, 25, 0);
        // Back-to-back stretch with no idling on either side.
        calm = 1'b1;
        random_burst(250, 55, 1);
        calm = 1'b0;
        random_burst(200, 50, 3);
        drain_replies();
        random_burst(250, 60, 1);

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mirror.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
